// ===== hdl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// clocked check, off while reset is high
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// clocked check that also runs through reset
`define ASSERT_CLK_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ===== hdl/lik_pkg.sv =====
package lik_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W = (CORDIC_STEPS > 2) ? $clog2(CORDIC_STEPS) : 1;
  localparam int TAB_IW = 5;
  localparam int CW = 34;
  localparam int AW = 20;

  localparam logic signed [AW-1:0] HALF_PI_Q16 = 20'sd102944;
  localparam logic signed [AW-1:0] PI_Q16 = 20'sd205887;

  localparam logic [1:0] REG_UPPER_LINK = 2'd0;
  localparam logic [1:0] REG_LOWER_LINK = 2'd1;
  localparam logic [1:0] REG_DEADBAND = 2'd2;

  typedef struct packed {
    logic start;
    logic signed [CW-1:0] num;
    logic signed [CW-1:0] den;
  } cordic_req_t;

  typedef struct packed {
    logic done;
    logic signed [AW-1:0] angle;
  } cordic_rsp_t;

  // atan(2^-i) in Q.16 radians
  function automatic logic signed [AW-1:0] atan_q16(input logic [TAB_IW-1:0] i);
    logic signed [AW-1:0] v;
    case (i)
      5'd0: v = 20'sd51472;
      5'd1: v = 20'sd30386;
      5'd2: v = 20'sd16055;
      5'd3: v = 20'sd8150;
      5'd4: v = 20'sd4091;
      5'd5: v = 20'sd2047;
      5'd6: v = 20'sd1024;
      5'd7: v = 20'sd512;
      5'd8: v = 20'sd256;
      5'd9: v = 20'sd128;
      5'd10: v = 20'sd64;
      5'd11: v = 20'sd32;
      5'd12: v = 20'sd16;
      5'd13: v = 20'sd8;
      5'd14: v = 20'sd4;
      5'd15: v = 20'sd2;
      5'd16: v = 20'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/leg_inverse_kinematics_3dof_core.sv =====
// a result follows every accepted target; the hip CORDIC step is skipped when the hip deadband
// applies, and the square roots, divisions and CORDIC steps are skipped when the reachability check fails
// a new target is taken only once the core is back in idle; the core uses one shared multiplier, a
// one-bit-per-cycle square root (21 steps), a restoring divider (17 steps) and one CORDIC unit
// (16 steps), one after another, but for the multiplier overlapping the start of one square root
// reset: link lengths 1024, deadband 0, held angles zero, no result pending
`include "assert_macros.svh"

module leg_inverse_kinematics_3dof_core
  import lik_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [14:0]        cfg_data,
  input  logic               target_valid,
  output logic               target_stall,
  input  logic signed [15:0] target_x,
  input  logic signed [15:0] target_y,
  input  logic signed [15:0] target_z,
  output logic               angle_valid,
  input  logic               angle_stall,
  output logic signed [15:0] hip_angle,
  output logic signed [15:0] upper_joint_angle,
  output logic signed [15:0] lower_joint_angle,
  output logic               reachable
);

  localparam logic [16:0] ONE_Q14 = 17'd16384;
  localparam logic [28:0] ONE_Q28 = 29'h1000_0000;

  typedef enum logic [25:0] {
    S_IDLE   = 26'h0000001,
    S_M0     = 26'h0000002,
    S_M1     = 26'h0000004,
    S_M2     = 26'h0000008,
    S_M3     = 26'h0000010,
    S_M4     = 26'h0000020,
    S_M5     = 26'h0000040,
    S_M6     = 26'h0000080,
    S_M7     = 26'h0000100,
    S_M8     = 26'h0000200,
    S_CHECK  = 26'h0000400,
    S_SQ_YV  = 26'h0000800,
    S_SQ_D   = 26'h0001000,
    S_M9     = 26'h0002000,
    S_M9W    = 26'h0004000,
    S_DV1    = 26'h0008000,
    S_DV2    = 26'h0010000,
    S_M10    = 26'h0020000,
    S_M10W   = 26'h0040000,
    S_SQ_S1  = 26'h0080000,
    S_SQ_S2  = 26'h0100000,
    S_AT0    = 26'h0200000,
    S_AT1    = 26'h0400000,
    S_AT2    = 26'h0800000,
    S_AT3    = 26'h1000000,
    S_FINISH = 26'h2000000
  } state_t;

  function automatic logic [15:0] to_q13(input logic signed [AW:0] v);
    logic signed [AW+1:0] w;
    logic signed [AW+1:0] r;
    logic signed [AW+1:0] rnd;
    rnd = (AW+2)'(4);
    w = (AW+2)'(v);
    if (w >= 0) r = (w + rnd) >>> 3;
    else r = -((-w + rnd) >>> 3);
    return r[15:0];
  endfunction

  state_t state, state_next;

  logic [14:0] l1, l2;
  logic [7:0]  dband;

  logic signed [15:0] tx, ty, tz;
  logic [15:0] ax, ay, az;

  logic        mul_en;
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;

  logic [31:0] r2, d2;
  logic [29:0] l1s;
  logic [30:0] l12x2;
  logic signed [33:0] num1, num2;
  logic [33:0] num1_neg, num2_neg;
  logic [31:0] n1abs, n2abs;
  logic [63:0] m1sq, rhs;
  logic        ok, ok_now;

  logic        sq_start, sq_busy, sq_done;
  logic [40:0] sq_arg, sq_v, sq_bit, sq_acos_arg;
  logic [41:0] sq_r, sq_sum;

  logic [20:0] yv16, d16;
  logic [14:0] s1, s2;

  logic        dv_start, dv_busy, dv_done, dv_neg, dv_neg_in, dv_ge;
  logic [50:0] dv_num, dv_rem;
  logic [37:0] dv_den;
  logic [53:0] dv_ds;
  logic [16:0] dv_q;
  logic [4:0]  dv_cnt;
  logic [14:0] dv_mag;
  logic signed [15:0] dv_c;
  logic signed [15:0] c1, c2;
  logic [15:0] c1_neg, c2_neg;
  logic [14:0] c1abs, c2abs;

  cordic_req_t cq;
  cordic_rsp_t cr;

  logic signed [AW-1:0] t0, hip, hip_special;
  logic signed [AW:0]   a1, a2;
  logic in_db;

  logic [15:0] held_hip, held_upper, held_lower;
  logic [15:0] rnd_hip, rnd_upper, rnd_lower;
  logic finish_go, out_take, in_take;

  lik_cordic u_cordic (
    .clk (clk),
    .rst (rst),
    .req (cq),
    .rsp (cr)
  );

  assign cfg_ready = !rst;
  assign target_stall = rst || (state != S_IDLE);
  assign in_take = target_valid && !target_stall;
  assign out_take = angle_valid && !angle_stall;
  assign finish_go = (state == S_FINISH) && (!angle_valid || !angle_stall);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      l1 <= 15'd1024;
      l2 <= 15'd1024;
      dband <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_UPPER_LINK: l1 <= cfg_data;
        REG_LOWER_LINK: l2 <= cfg_data;
        REG_DEADBAND:   dband <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign ax = tx[15] ? 16'(-tx) : 16'(tx);
  assign ay = ty[15] ? 16'(-ty) : 16'(ty);
  assign az = tz[15] ? 16'(-tz) : 16'(tz);
  assign num1_neg = 34'(-num1);
  assign num2_neg = 34'(-num2);
  assign n1abs = num1[33] ? num1_neg[31:0] : num1[31:0];
  assign n2abs = num2[33] ? num2_neg[31:0] : num2[31:0];
  assign c1_neg = 16'(-c1);
  assign c2_neg = 16'(-c2);
  assign c1abs = c1[15] ? c1_neg[14:0] : c1[14:0];
  assign c2abs = c2[15] ? c2_neg[14:0] : c2[14:0];

  assign ok_now = (d2 != '0) && (l1 != '0) && (l2 != '0) && (m1sq <= rhs)
                  && (n2abs <= {1'b0, l12x2});
  assign sq_acos_arg = {12'b0, ONE_Q28 - prod[28:0]};

  assign in_db = ay < {8'b0, dband};
  always_comb begin
    if (tx > 0) hip_special = HALF_PI_Q16;
    else if (tx < 0) hip_special = -HALF_PI_Q16;
    else hip_special = '0;
  end

  // sequencer and unit issue
  always_comb begin
    state_next = state;
    mul_en = 1'b0;
    mul_a = '0;
    mul_b = '0;
    sq_start = 1'b0;
    sq_arg = '0;
    dv_start = 1'b0;
    dv_num = '0;
    dv_den = '0;
    dv_neg_in = 1'b0;
    cq = '0;
    unique case (state)
      S_IDLE: if (in_take) state_next = S_M0;
      S_M0: begin
        mul_en = 1'b1; mul_a = {16'b0, ax}; mul_b = {16'b0, ax};
        state_next = S_M1;
      end
      S_M1: begin
        mul_en = 1'b1; mul_a = {16'b0, ay}; mul_b = {16'b0, ay};
        state_next = S_M2;
      end
      S_M2: begin
        mul_en = 1'b1; mul_a = {16'b0, az}; mul_b = {16'b0, az};
        state_next = S_M3;
      end
      S_M3: begin
        mul_en = 1'b1; mul_a = {17'b0, l1}; mul_b = {17'b0, l1};
        state_next = S_M4;
      end
      S_M4: begin
        mul_en = 1'b1; mul_a = {17'b0, l2}; mul_b = {17'b0, l2};
        state_next = S_M5;
      end
      S_M5: begin
        mul_en = 1'b1; mul_a = {17'b0, l1}; mul_b = {17'b0, l2};
        state_next = S_M6;
      end
      S_M6: begin
        mul_en = 1'b1; mul_a = n1abs; mul_b = n1abs;
        state_next = S_M7;
      end
      S_M7: begin
        mul_en = 1'b1; mul_a = d2; mul_b = {2'b0, l1s};
        state_next = S_M8;
      end
      S_M8: state_next = S_CHECK;
      S_CHECK: begin
        if (ok_now) begin
          sq_start = 1'b1;
          sq_arg = {1'b0, r2, 8'b0};
          state_next = S_SQ_YV;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_SQ_YV: if (sq_done) begin
        sq_start = 1'b1;
        sq_arg = {1'b0, d2, 8'b0};
        state_next = S_SQ_D;
      end
      S_SQ_D: if (sq_done) state_next = S_M9;
      S_M9: begin
        mul_en = 1'b1; mul_a = {11'b0, d16}; mul_b = {17'b0, l1};
        state_next = S_M9W;
      end
      S_M9W: begin
        dv_start = 1'b1;
        dv_num = {1'b0, n1abs, 18'b0};
        dv_den = {prod[36:0], 1'b0};
        dv_neg_in = num1[33];
        state_next = S_DV1;
      end
      S_DV1: if (dv_done) begin
        dv_start = 1'b1;
        dv_num = {5'b0, n2abs, 14'b0};
        dv_den = {7'b0, l12x2};
        dv_neg_in = num2[33];
        state_next = S_DV2;
      end
      S_DV2: if (dv_done) state_next = S_M10;
      S_M10: begin
        mul_en = 1'b1; mul_a = {17'b0, c1abs}; mul_b = {17'b0, c1abs};
        state_next = S_M10W;
      end
      S_M10W: begin
        sq_start = 1'b1;
        sq_arg = sq_acos_arg;
        mul_en = 1'b1; mul_a = {17'b0, c2abs}; mul_b = {17'b0, c2abs};
        state_next = S_SQ_S1;
      end
      S_SQ_S1: if (sq_done) begin
        sq_start = 1'b1;
        sq_arg = sq_acos_arg;
        state_next = S_SQ_S2;
      end
      S_SQ_S2: if (sq_done) begin
        cq.start = 1'b1;
        cq.num = $signed({13'b0, yv16});
        cq.den = CW'(tz) <<< 4;
        state_next = S_AT0;
      end
      S_AT0: if (cr.done) begin
        cq.start = 1'b1;
        cq.num = $signed({19'b0, s1});
        cq.den = CW'(c1);
        state_next = S_AT1;
      end
      S_AT1: if (cr.done) begin
        cq.start = 1'b1;
        cq.num = $signed({19'b0, s2});
        cq.den = CW'(c2);
        state_next = S_AT2;
      end
      S_AT2: if (cr.done) begin
        if (in_db) begin
          state_next = S_FINISH;
        end else begin
          cq.start = 1'b1;
          cq.num = CW'(tx);
          cq.den = CW'(ty);
          state_next = S_AT3;
        end
      end
      S_AT3: if (cr.done) state_next = S_FINISH;
      S_FINISH: if (finish_go) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (mul_en) prod <= mul_a * mul_b;
  end

  // working registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: if (in_take) begin
        tx <= target_x;
        ty <= target_y;
        tz <= target_z;
      end
      S_M1: r2 <= prod[31:0];
      S_M2: r2 <= r2 + prod[31:0];
      S_M3: d2 <= r2 + prod[31:0];
      S_M4: begin
        l1s <= prod[29:0];
        num1 <= $signed({2'b00, d2}) + $signed({4'b0000, prod[29:0]});
        num2 <= $signed({4'b0000, prod[29:0]}) - $signed({2'b00, d2});
      end
      S_M5: begin
        num1 <= num1 - $signed({4'b0000, prod[29:0]});
        num2 <= num2 + $signed({4'b0000, prod[29:0]});
      end
      S_M6: l12x2 <= {prod[29:0], 1'b0};
      S_M7: m1sq <= prod;
      S_M8: rhs <= {prod[61:0], 2'b00};
      S_CHECK: ok <= ok_now;
      S_SQ_YV: if (sq_done) yv16 <= sq_r[20:0];
      S_SQ_D: if (sq_done) d16 <= sq_r[20:0];
      S_DV1: if (dv_done) c1 <= dv_c;
      S_DV2: if (dv_done) c2 <= dv_c;
      S_SQ_S1: if (sq_done) s1 <= sq_r[14:0];
      S_SQ_S2: if (sq_done) s2 <= sq_r[14:0];
      S_AT0: if (cr.done) t0 <= cr.angle;
      S_AT1: if (cr.done) a1 <= (AW+1)'(t0) - (AW+1)'(cr.angle);
      S_AT2: if (cr.done) begin
        a2 <= (AW+1)'(PI_Q16) - (AW+1)'(cr.angle);
        if (in_db) hip <= hip_special;
      end
      S_AT3: if (cr.done) hip <= cr.angle;
      default: ;
    endcase
  end

  // floor square root, one result bit per cycle
  assign sq_sum = sq_r + {1'b0, sq_bit};

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_busy <= 1'b0;
      sq_done <= 1'b0;
    end else begin
      sq_done <= 1'b0;
      if (sq_start) begin
        sq_busy <= 1'b1;
      end else if (sq_busy && sq_bit[0]) begin
        sq_busy <= 1'b0;
        sq_done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sq_start) begin
      sq_v <= sq_arg;
      sq_r <= '0;
      sq_bit <= {1'b1, 40'b0};
    end else if (sq_busy) begin
      if ({1'b0, sq_v} >= sq_sum) begin
        sq_v <= sq_v - sq_sum[40:0];
        sq_r <= (sq_r >> 1) + {1'b0, sq_bit};
      end else begin
        sq_r <= sq_r >> 1;
      end
      sq_bit <= sq_bit >> 2;
    end
  end

  // restoring divider, 17 quotient bits, ratio clamped to one
  assign dv_ge = {3'b0, dv_rem} >= dv_ds;
  assign dv_mag = (dv_q > ONE_Q14) ? ONE_Q14[14:0] : dv_q[14:0];
  assign dv_c = dv_neg ? -$signed({1'b0, dv_mag}) : $signed({1'b0, dv_mag});

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_busy <= 1'b0;
      dv_done <= 1'b0;
      dv_cnt <= '0;
    end else begin
      dv_done <= 1'b0;
      if (dv_start) begin
        dv_busy <= 1'b1;
        dv_cnt <= '0;
      end else if (dv_busy) begin
        dv_cnt <= dv_cnt + 1'b1;
        if (dv_cnt == 5'd16) begin
          dv_busy <= 1'b0;
          dv_done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dv_start) begin
      dv_rem <= dv_num;
      dv_ds <= {dv_den, 16'b0};
      dv_q <= '0;
      dv_neg <= dv_neg_in;
    end else if (dv_busy) begin
      if (dv_ge) begin
        dv_rem <= dv_rem - dv_ds[50:0];
        dv_q <= {dv_q[15:0], 1'b1};
      end else begin
        dv_q <= {dv_q[15:0], 1'b0};
      end
      dv_ds <= dv_ds >> 1;
    end
  end

  // result and held angles
  assign rnd_hip = to_q13((AW+1)'(hip));
  assign rnd_upper = to_q13(a1);
  assign rnd_lower = to_q13(a2);

  always_ff @(posedge clk) begin
    if (rst) begin
      held_hip <= '0;
      held_upper <= '0;
      held_lower <= '0;
    end else if (finish_go && ok) begin
      held_hip <= rnd_hip;
      held_upper <= rnd_upper;
      held_lower <= rnd_lower;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) angle_valid <= 1'b0;
    else if (finish_go) angle_valid <= 1'b1;
    else if (out_take) angle_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (finish_go) begin
      hip_angle <= $signed(ok ? rnd_hip : held_hip);
      upper_joint_angle <= $signed(ok ? rnd_upper : held_upper);
      lower_joint_angle <= $signed(ok ? rnd_lower : held_lower);
      reachable <= ok;
    end
  end

  `ASSERT_CLK(a_unreach_holds, (angle_valid && !reachable) |-> (hip_angle == held_hip && upper_joint_angle == held_upper && lower_joint_angle == held_lower), "unreachable result differs from held angles")
  `ASSERT_CLK(a_units_exclusive, $onehot0({sq_busy, dv_busy}), "square root and divider busy together")
  `ASSERT_CLK(a_take_starts, in_take |=> (state == S_M0 && !sq_busy && !dv_busy), "accepted transaction did not start cleanly")
  `ASSERT_CLK_RST(a_reset_clear, rst |=> (state == S_IDLE && !angle_valid), "reset left work pending")

endmodule

// ===== hdl/lik_cordic.sv =====
module lik_cordic
  import lik_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cordic_req_t req,
  output cordic_rsp_t rsp
);

  logic                 busy;
  logic                 done;
  logic [STEP_W-1:0]    cnt;
  logic signed [CW-1:0] x, y, x0, y0, xs, ys, dx, dy;
  logic signed [AW-1:0] a, a0, ang;
  logic                 both_zero;

  // scale and pre-rotate into the right half plane
  always_comb begin
    xs = req.den <<< 8;
    ys = req.num <<< 8;
    both_zero = (req.num == '0) && (req.den == '0);
    x0 = xs;
    y0 = ys;
    a0 = '0;
    if (xs < 0) begin
      if (ys >= 0) begin
        x0 = ys;
        y0 = -xs;
        a0 = HALF_PI_Q16;
      end else begin
        x0 = -ys;
        y0 = xs;
        a0 = -HALF_PI_Q16;
      end
    end
  end

  assign dx = y >>> cnt;
  assign dy = x >>> cnt;
  assign ang = atan_q16(TAB_IW'(cnt));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= !both_zero;
        done <= both_zero;
        cnt <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == STEP_W'(CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      x <= x0;
      y <= y0;
      a <= both_zero ? '0 : a0;
    end else if (busy) begin
      if (y > 0) begin
        x <= x + dx;
        y <= y - dy;
        a <= a + ang;
      end else begin
        x <= x - dx;
        y <= y + dy;
        a <= a - ang;
      end
    end
  end

  assign rsp.done = done;
  assign rsp.angle = a;

endmodule
